FILE: sv/inverse_depth_observer_step_defines.svh
// Assertion macros shared by the observer RTL.
// No dependencies; included by inverse_depth_observer_step, which carries checks.
`ifndef INVERSE_DEPTH_OBSERVER_STEP_DEFINES_SVH
`define INVERSE_DEPTH_OBSERVER_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define IDO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IDO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define IDO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/ido_pkg.sv
// Types, constants, saturating arithmetic helpers and the microcode ROM
// of the inverse-depth observer. No dependencies.
package ido_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int WIDE_W     = DATA_WIDTH + FRAC_BITS;
  localparam int DT_W       = 20;
  localparam int GAIN_W     = 31;
  localparam int PC_W       = 7;

  localparam logic [DATA_WIDTH-1:0] ONE_FX = DATA_WIDTH'(64'd1 << FRAC_BITS);
  localparam logic [DATA_WIDTH-1:0] INV_DEPTH_INIT =
    DATA_WIDTH'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [GAIN_W-1:0] GAIN_INIT = GAIN_W'(64'd4 << FRAC_BITS);

  // configuration register indexes
  localparam logic [1:0] CFG_GAIN_ONE   = 2'd0;
  localparam logic [1:0] CFG_GAIN_TWO   = 2'd1;
  localparam logic [1:0] CFG_GAIN_THREE = 2'd2;
  localparam logic [1:0] CFG_PRED_EN    = 2'd3;

  typedef struct packed {
    logic                   action;
    logic signed [31:0]     meas_x;
    logic signed [31:0]     meas_y;
    logic signed [31:0]     rel_vel_x;
    logic signed [31:0]     rel_vel_y;
    logic signed [31:0]     rel_vel_z;
    logic signed [31:0]     ang_vel_x;
    logic signed [31:0]     ang_vel_y;
    logic signed [31:0]     ang_vel_z;
    logic [DT_W-1:0]        delta_t;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_inv_depth;
    logic               was_predicted;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_END
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_READ, ST_ISSUE, ST_WAIT
  } state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_ctl_t;

  // operand / destination codes: scratch entries below 32, named registers from 32 up
  typedef logic [5:0] src_t;
  localparam src_t T0 = 6'd0,  T1 = 6'd1,  T2 = 6'd2,  T3 = 6'd3,  T4 = 6'd4;
  localparam src_t T5 = 6'd5,  T6 = 6'd6,  T7 = 6'd7,  T8 = 6'd8,  T9 = 6'd9;
  localparam src_t T10 = 6'd10, T11 = 6'd11, T12 = 6'd12, T13 = 6'd13;
  localparam src_t T14 = 6'd14, T15 = 6'd15, T16 = 6'd16, T17 = 6'd17;
  localparam src_t R_ZERO = 6'd32, R_ONE = 6'd33, R_Y1 = 6'd34, R_Y2 = 6'd35;
  localparam src_t R_B1 = 6'd36, R_B2 = 6'd37, R_B3 = 6'd38;
  localparam src_t R_A1 = 6'd39, R_A2 = 6'd40, R_A3 = 6'd41;
  localparam src_t R_X1 = 6'd42, R_X2 = 6'd43, R_X3 = 6'd44;
  localparam src_t R_L1 = 6'd45, R_L2 = 6'd46;
  localparam src_t R_G1 = 6'd47, R_G2 = 6'd48, R_G3 = 6'd49, R_DT = 6'd50;

  typedef struct packed {
    op_t  op;
    src_t dst;
    src_t a;
    src_t b;
  } instr_t;

  localparam logic [PC_W-1:0] PC_MEAS = 7'd0;
  localparam logic [PC_W-1:0] PC_PRED = 7'd73;
  localparam logic [PC_W-1:0] PC_HOLD = 7'd113;

  function automatic logic [DATA_WIDTH-1:0] sat_addsub(
    input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b, input logic sub);
    logic signed [DATA_WIDTH:0] s;
    logic signed [DATA_WIDTH:0] sa;
    logic signed [DATA_WIDTH:0] sb;
    sa = {a[DATA_WIDTH-1], a};
    sb = {b[DATA_WIDTH-1], b};
    s  = sub ? sa - sb : sa + sb;
    if (s[DATA_WIDTH] != s[DATA_WIDTH-1])
      return s[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
    return s[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_WIDTH-1:0] magn(input logic [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? DATA_WIDTH'(0) - v : v;
  endfunction

  // clamp an unsigned magnitude, then apply the sign
  function automatic logic [DATA_WIDTH-1:0] sat_mag(
    input logic [WIDE_W-1:0] m, input logic neg);
    logic [WIDE_W-1:0]     lim;
    logic [DATA_WIDTH-1:0] v;
    lim = {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}} + WIDE_W'(neg);
    v   = (m > lim) ? lim[DATA_WIDTH-1:0] : m[DATA_WIDTH-1:0];
    return neg ? DATA_WIDTH'(0) - v : v;
  endfunction

  function automatic instr_t mk(input op_t op, input src_t d, input src_t a, input src_t b);
    instr_t r;
    r.op = op; r.dst = d; r.a = a; r.b = b;
    return r;
  endfunction

  // shared tail: integrate the three rates held in T14, T15, T17 over delta_t, then copy Y1, Y2 to L1, L2
  function automatic instr_t tail(input logic [3:0] k);
    instr_t r;
    unique case (k)
      4'd0:    r = mk(OP_MUL, T3, T14, R_DT);
      4'd1:    r = mk(OP_ADD, R_X1, R_X1, T3);
      4'd2:    r = mk(OP_MUL, T3, T15, R_DT);
      4'd3:    r = mk(OP_ADD, R_X2, R_X2, T3);
      4'd4:    r = mk(OP_MUL, T3, T17, R_DT);
      4'd5:    r = mk(OP_ADD, R_X3, R_X3, T3);
      4'd6:    r = mk(OP_ADD, R_L1, R_Y1, R_ZERO);
      4'd7:    r = mk(OP_ADD, R_L2, R_Y2, R_ZERO);
      default: r = mk(OP_END, R_ZERO, R_ZERO, R_ZERO);
    endcase
    return r;
  endfunction

  function automatic instr_t ucode(input logic [PC_W-1:0] pc);
    instr_t r;
    unique case (pc)
      // measurement update
      7'd0:  r = mk(OP_SUB, T0, R_ZERO, R_A1);
      7'd1:  r = mk(OP_SUB, T1, R_ZERO, R_A2);
      7'd2:  r = mk(OP_SUB, T2, R_ZERO, R_A3);
      7'd3:  r = mk(OP_MUL, T3, R_Y1, R_B3);
      7'd4:  r = mk(OP_SUB, T4, R_B1, T3);
      7'd5:  r = mk(OP_MUL, T3, R_Y2, R_B3);
      7'd6:  r = mk(OP_SUB, T5, R_B2, T3);
      7'd7:  r = mk(OP_MUL, T6, R_Y1, R_Y2);
      7'd8:  r = mk(OP_MUL, T3, T6, T0);
      7'd9:  r = mk(OP_SUB, T3, R_ZERO, T3);
      7'd10: r = mk(OP_MUL, T7, R_Y1, R_Y1);
      7'd11: r = mk(OP_ADD, T7, R_ONE, T7);
      7'd12: r = mk(OP_MUL, T7, T7, T1);
      7'd13: r = mk(OP_ADD, T3, T3, T7);
      7'd14: r = mk(OP_MUL, T7, R_Y2, T2);
      7'd15: r = mk(OP_SUB, T8, T3, T7);
      7'd16: r = mk(OP_MUL, T3, R_Y2, R_Y2);
      7'd17: r = mk(OP_ADD, T3, R_ONE, T3);
      7'd18: r = mk(OP_MUL, T3, T3, T0);
      7'd19: r = mk(OP_SUB, T3, R_ZERO, T3);
      7'd20: r = mk(OP_MUL, T7, T6, T1);
      7'd21: r = mk(OP_ADD, T3, T3, T7);
      7'd22: r = mk(OP_MUL, T7, R_Y1, T2);
      7'd23: r = mk(OP_ADD, T9, T3, T7);
      7'd24: r = mk(OP_SUB, T10, R_Y1, R_X1);
      7'd25: r = mk(OP_SUB, T11, R_Y2, R_X2);
      7'd26: r = mk(OP_SUB, T3, R_Y1, R_L1);
      7'd27: r = mk(OP_DIV, T12, T3, R_DT);
      7'd28: r = mk(OP_SUB, T3, R_Y2, R_L2);
      7'd29: r = mk(OP_DIV, T13, T3, R_DT);
      7'd30: r = mk(OP_MUL, T3, T4, R_X3);
      7'd31: r = mk(OP_ADD, T3, T3, T8);
      7'd32: r = mk(OP_MUL, T7, R_G1, T10);
      7'd33: r = mk(OP_ADD, T14, T3, T7);
      7'd34: r = mk(OP_MUL, T3, T5, R_X3);
      7'd35: r = mk(OP_ADD, T3, T3, T9);
      7'd36: r = mk(OP_MUL, T7, R_G2, T11);
      7'd37: r = mk(OP_ADD, T15, T3, T7);
      7'd38: r = mk(OP_MUL, T3, R_X3, R_X3);
      7'd39: r = mk(OP_MUL, T3, R_B3, T3);
      7'd40: r = mk(OP_SUB, T16, R_ZERO, T3);
      7'd41: r = mk(OP_MUL, T3, R_Y1, T1);
      7'd42: r = mk(OP_MUL, T7, R_Y2, T0);
      7'd43: r = mk(OP_SUB, T3, T3, T7);
      7'd44: r = mk(OP_MUL, T3, T3, R_X3);
      7'd45: r = mk(OP_ADD, T16, T16, T3);
      7'd46: r = mk(OP_MUL, T3, T4, T4);
      7'd47: r = mk(OP_MUL, T7, T5, T5);
      7'd48: r = mk(OP_ADD, T3, T3, T7);
      7'd49: r = mk(OP_MUL, T3, R_G3, T3);
      7'd50: r = mk(OP_MUL, T3, T3, R_X3);
      7'd51: r = mk(OP_SUB, T16, T16, T3);
      7'd52: r = mk(OP_MUL, T3, R_G3, T4);
      7'd53: r = mk(OP_SUB, T7, T12, T8);
      7'd54: r = mk(OP_MUL, T3, T3, T7);
      7'd55: r = mk(OP_ADD, T16, T16, T3);
      7'd56: r = mk(OP_MUL, T3, R_G3, T5);
      7'd57: r = mk(OP_SUB, T7, T13, T9);
      7'd58: r = mk(OP_MUL, T3, T3, T7);
      7'd59: r = mk(OP_ADD, T16, T16, T3);
      7'd60: r = mk(OP_MUL, T3, T4, T10);
      7'd61: r = mk(OP_ADD, T16, T16, T3);
      7'd62: r = mk(OP_MUL, T3, T5, T11);
      7'd63: r = mk(OP_ADD, T17, T16, T3);
      7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71, 7'd72:
        r = tail(4'(pc - 7'd64));
      // open-loop prediction
      7'd73: r = mk(OP_MUL, T6, R_X1, R_X2);
      7'd74: r = mk(OP_MUL, T3, R_A3, R_X2);
      7'd75: r = mk(OP_SUB, T3, T3, R_A2);
      7'd76: r = mk(OP_MUL, T7, R_X1, R_X1);
      7'd77: r = mk(OP_MUL, T7, R_A2, T7);
      7'd78: r = mk(OP_SUB, T3, T3, T7);
      7'd79: r = mk(OP_MUL, T7, R_A1, T6);
      7'd80: r = mk(OP_ADD, T3, T3, T7);
      7'd81: r = mk(OP_MUL, T7, R_X1, R_B3);
      7'd82: r = mk(OP_SUB, T7, R_B1, T7);
      7'd83: r = mk(OP_MUL, T7, T7, R_X3);
      7'd84: r = mk(OP_ADD, T14, T3, T7);
      7'd85: r = mk(OP_MUL, T7, R_A3, R_X1);
      7'd86: r = mk(OP_SUB, T3, R_A1, T7);
      7'd87: r = mk(OP_MUL, T7, R_A2, T6);
      7'd88: r = mk(OP_SUB, T3, T3, T7);
      7'd89: r = mk(OP_MUL, T7, R_X2, R_X2);
      7'd90: r = mk(OP_MUL, T7, R_A1, T7);
      7'd91: r = mk(OP_ADD, T3, T3, T7);
      7'd92: r = mk(OP_MUL, T7, R_X2, R_B3);
      7'd93: r = mk(OP_SUB, T7, R_B2, T7);
      7'd94: r = mk(OP_MUL, T7, T7, R_X3);
      7'd95: r = mk(OP_ADD, T15, T3, T7);
      7'd96: r = mk(OP_MUL, T3, R_X3, R_X3);
      7'd97: r = mk(OP_MUL, T3, R_B3, T3);
      7'd98: r = mk(OP_SUB, T3, R_ZERO, T3);
      7'd99: r = mk(OP_MUL, T7, R_A2, R_X1);
      7'd100: r = mk(OP_MUL, T8, R_A1, R_X2);
      7'd101: r = mk(OP_SUB, T7, T7, T8);
      7'd102: r = mk(OP_MUL, T7, T7, R_X3);
      7'd103: r = mk(OP_SUB, T17, T3, T7);
      7'd104, 7'd105, 7'd106, 7'd107, 7'd108, 7'd109, 7'd110, 7'd111, 7'd112:
        r = tail(4'(pc - 7'd104));
      // prediction off: only the position is stored
      7'd113: r = mk(OP_ADD, R_L1, R_Y1, R_ZERO);
      7'd114: r = mk(OP_ADD, R_L2, R_Y2, R_ZERO);
      default: r = mk(OP_END, R_ZERO, R_ZERO, R_ZERO);
    endcase
    return r;
  endfunction

endpackage

FILE: sv/ido_alu.sv
// Shared arithmetic unit: saturating add/sub, fixed-point multiply and
// a restoring divider one quotient bit per cycle. Depends on ido_pkg.
module ido_alu (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ido_pkg::alu_ctl_t                ctl,
  input  logic [ido_pkg::DATA_WIDTH-1:0]   opa,
  input  logic [ido_pkg::DATA_WIDTH-1:0]   opb,
  input  logic [ido_pkg::DT_W-1:0]         den,
  output logic [ido_pkg::DATA_WIDTH-1:0]   res,
  output logic                             done
);

  localparam int DW  = ido_pkg::DATA_WIDTH;
  localparam int WW  = ido_pkg::WIDE_W;
  localparam int CW  = $clog2(WW + 1);

  logic [2*DW-1:0]   prod_r;
  logic              neg_r;
  logic              mul_pend_r;
  logic [CW-1:0]     cnt_r;
  logic              div_fin_r;
  logic [WW-1:0]     dvd_r;
  logic [WW-1:0]     quo_r;
  logic [ido_pkg::DT_W-1:0] rem_r;
  logic [DW-1:0]     res_r;
  logic              done_r;
  logic [ido_pkg::DT_W:0]   rem_sh;
  logic              q_bit;

  assign rem_sh = {rem_r, dvd_r[WW-1]};
  assign q_bit  = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_pend_r <= 1'b0;
      cnt_r      <= '0;
      div_fin_r  <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r     <= 1'b0;
      mul_pend_r <= 1'b0;
      div_fin_r  <= 1'b0;
      if (ctl.start) begin
        unique case (ctl.op)
          ido_pkg::OP_ADD: begin
            res_r  <= ido_pkg::sat_addsub(opa, opb, 1'b0);
            done_r <= 1'b1;
          end
          ido_pkg::OP_SUB: begin
            res_r  <= ido_pkg::sat_addsub(opa, opb, 1'b1);
            done_r <= 1'b1;
          end
          ido_pkg::OP_MUL: begin
            prod_r     <= ido_pkg::magn(opa) * ido_pkg::magn(opb);
            neg_r      <= opa[DW-1] ^ opb[DW-1];
            mul_pend_r <= 1'b1;
          end
          ido_pkg::OP_DIV: begin
            dvd_r <= {ido_pkg::magn(opa), {ido_pkg::FRAC_BITS{1'b0}}};
            quo_r <= '0;
            rem_r <= '0;
            neg_r <= opa[DW-1];
            cnt_r <= CW'(WW);
          end
          default: done_r <= 1'b1;
        endcase
      end
      if (mul_pend_r) begin
        res_r  <= ido_pkg::sat_mag(prod_r[2*DW-1:ido_pkg::FRAC_BITS], neg_r);
        done_r <= 1'b1;
      end
      if (cnt_r != '0) begin
        rem_r <= q_bit ? ido_pkg::DT_W'(rem_sh - {1'b0, den}) : rem_sh[ido_pkg::DT_W-1:0];
        quo_r <= {quo_r[WW-2:0], q_bit};
        dvd_r <= {dvd_r[WW-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) div_fin_r <= 1'b1;
      end
      if (div_fin_r) begin
        res_r  <= ido_pkg::sat_mag(quo_r, neg_r);
        done_r <= 1'b1;
      end
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

FILE: sv/inverse_depth_observer_step.sv
// Inverse-depth feature observer. A microcoded sequencer issues operations one
// after another to a single shared unit; the divider in that unit is bit-serial
// and produces 48 quotient bits. A measurement item runs 72 operations (37
// add/sub, 33 multiply, 2 divide) and a prediction item runs 39 operations (18
// add/sub, 21 multiply); with prediction off a predict item runs 2 adds. The
// result is loaded into the output register when the sequencer reaches its last
// step, and a new item is accepted only once the sequencer is idle again, so the
// block does not take an item while the last one is in flight. in_stall is high
// from the cycle after acceptance until the result is placed in the output
// register; while that register holds an unaccepted result the sequencer waits
// at its last step. A measurement with zero delta_t is accepted while the
// sequencer stays idle and produces no result.
// Depends on ido_pkg, ido_alu and inverse_depth_observer_step_defines.svh.
`include "inverse_depth_observer_step_defines.svh"

module inverse_depth_observer_step (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ido_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ido_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [ido_pkg::GAIN_W-1:0]     cfg_wdata
);

  localparam int DW = ido_pkg::DATA_WIDTH;

  ido_pkg::state_t     state_r, state_nxt;
  logic [ido_pkg::PC_W-1:0] pc_r;
  ido_pkg::in_item_t   in_r;
  ido_pkg::instr_t     ins;
  ido_pkg::alu_ctl_t   alu_ctl;
  ido_pkg::out_item_t  out_r;
  logic                out_valid_r;
  logic [DW-1:0] x1_r, x2_r, x3_r, l1_r, l2_r;
  logic [ido_pkg::GAIN_W-1:0] g1_r, g2_r, g3_r;
  logic          pen_r;
  logic [DW-1:0] tmp_mem [32];
  logic [DW-1:0] rd_a_r, rd_b_r, spec_a_r, spec_b_r;
  logic [DW-1:0] opa, opb, alu_res;
  logic          alu_done;
  logic          in_xfer, out_xfer, drop, out_load, wr_en;

  assign ins      = ido_pkg::ucode(pc_r);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign drop     = !in_data.action && (in_data.delta_t == '0);
  assign out_load = (state_r == ido_pkg::ST_READ) && (ins.op == ido_pkg::OP_END) &&
                    (!out_valid_r || out_xfer);
  assign wr_en    = (state_r == ido_pkg::ST_WAIT) && alu_done;

  function automatic logic [DW-1:0] spec(input ido_pkg::src_t s,
      input ido_pkg::in_item_t it, input logic [DW-1:0] x1, input logic [DW-1:0] x2,
      input logic [DW-1:0] x3, input logic [DW-1:0] l1, input logic [DW-1:0] l2,
      input logic [ido_pkg::GAIN_W-1:0] g1, input logic [ido_pkg::GAIN_W-1:0] g2,
      input logic [ido_pkg::GAIN_W-1:0] g3);
    logic [DW-1:0] v;
    unique case (s)
      ido_pkg::R_ONE: v = ido_pkg::ONE_FX;
      ido_pkg::R_Y1:  v = it.meas_x;
      ido_pkg::R_Y2:  v = it.meas_y;
      ido_pkg::R_B1:  v = it.rel_vel_x;
      ido_pkg::R_B2:  v = it.rel_vel_y;
      ido_pkg::R_B3:  v = it.rel_vel_z;
      ido_pkg::R_A1:  v = it.ang_vel_x;
      ido_pkg::R_A2:  v = it.ang_vel_y;
      ido_pkg::R_A3:  v = it.ang_vel_z;
      ido_pkg::R_X1:  v = x1;
      ido_pkg::R_X2:  v = x2;
      ido_pkg::R_X3:  v = x3;
      ido_pkg::R_L1:  v = l1;
      ido_pkg::R_L2:  v = l2;
      ido_pkg::R_G1:  v = DW'(g1);
      ido_pkg::R_G2:  v = DW'(g2);
      ido_pkg::R_G3:  v = DW'(g3);
      ido_pkg::R_DT:  v = DW'(it.delta_t);
      default:        v = '0;
    endcase
    return v;
  endfunction

  // operand fetch: scratch memory and named registers, both registered
  always_ff @(posedge clk) begin
    rd_a_r   <= tmp_mem[ins.a[4:0]];
    rd_b_r   <= tmp_mem[ins.b[4:0]];
    spec_a_r <= spec(ins.a, in_r, x1_r, x2_r, x3_r, l1_r, l2_r, g1_r, g2_r, g3_r);
    spec_b_r <= spec(ins.b, in_r, x1_r, x2_r, x3_r, l1_r, l2_r, g1_r, g2_r, g3_r);
    if (wr_en && !ins.dst[5]) tmp_mem[ins.dst[4:0]] <= alu_res;
  end

  assign opa = ins.a[5] ? spec_a_r : rd_a_r;
  assign opb = ins.b[5] ? spec_b_r : rd_b_r;

  ido_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alu_ctl),
    .opa   (opa),
    .opb   (opb),
    .den   (in_r.delta_t),
    .res   (alu_res),
    .done  (alu_done)
  );

  always_comb begin
    state_nxt     = state_r;
    in_stall      = (state_r != ido_pkg::ST_IDLE);
    alu_ctl.start = 1'b0;
    alu_ctl.op    = ins.op;
    unique case (state_r)
      ido_pkg::ST_IDLE: begin
        if (in_xfer && !drop) state_nxt = ido_pkg::ST_READ;
      end
      ido_pkg::ST_READ: begin
        if (ins.op != ido_pkg::OP_END) state_nxt = ido_pkg::ST_ISSUE;
        else if (out_load) state_nxt = ido_pkg::ST_IDLE;
      end
      ido_pkg::ST_ISSUE: begin
        alu_ctl.start = 1'b1;
        state_nxt     = ido_pkg::ST_WAIT;
      end
      ido_pkg::ST_WAIT: begin
        if (alu_done) state_nxt = ido_pkg::ST_READ;
      end
      default: state_nxt = ido_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ido_pkg::ST_IDLE;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      x1_r        <= '0;
      x2_r        <= '0;
      x3_r        <= ido_pkg::INV_DEPTH_INIT;
      l1_r        <= '0;
      l2_r        <= '0;
      g1_r        <= ido_pkg::GAIN_INIT;
      g2_r        <= ido_pkg::GAIN_INIT;
      g3_r        <= ido_pkg::GAIN_INIT;
      pen_r       <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        in_r <= in_data;
        if (!in_data.action)  pc_r <= ido_pkg::PC_MEAS;
        else if (pen_r)       pc_r <= ido_pkg::PC_PRED;
        else                  pc_r <= ido_pkg::PC_HOLD;
      end
      if (wr_en) begin
        pc_r <= pc_r + ido_pkg::PC_W'(1);
        unique case (ins.dst)
          ido_pkg::R_X1: x1_r <= alu_res;
          ido_pkg::R_X2: x2_r <= alu_res;
          ido_pkg::R_X3: x3_r <= alu_res;
          ido_pkg::R_L1: l1_r <= alu_res;
          ido_pkg::R_L2: l2_r <= alu_res;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r         <= 1'b1;
        out_r.est_x         <= x1_r;
        out_r.est_y         <= x2_r;
        out_r.est_inv_depth <= x3_r;
        out_r.was_predicted <= in_r.action;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ido_pkg::CFG_GAIN_ONE:   g1_r  <= cfg_wdata;
          ido_pkg::CFG_GAIN_TWO:   g2_r  <= cfg_wdata;
          ido_pkg::CFG_GAIN_THREE: g3_r  <= cfg_wdata;
          ido_pkg::CFG_PRED_EN:    pen_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `IDO_ASSERT_IMPL(a_accept_idle, clk, rst_n, in_xfer, state_r == ido_pkg::ST_IDLE)
  `IDO_ASSERT_IMPL(a_done_in_wait, clk, rst_n, alu_done, state_r == ido_pkg::ST_WAIT)
  `IDO_ASSERT_NEXT(a_load_valid, clk, rst_n, out_load, out_valid_r && state_r == ido_pkg::ST_IDLE)
  `IDO_ASSERT_NEXT(a_drop_idle, clk, rst_n, in_xfer && drop, state_r == ido_pkg::ST_IDLE)

endmodule

FILE: verif/tb_top.sv
// Testbench for inverse_depth_observer_step: drives measurement and predict
// transfers, predicts each estimate in Q16.16 and checks every result.
// Depends on ido_pkg and the observer RTL.
module tb_top;

  localparam logic [31:0] FX_MAX = 32'h7fffffff;
  localparam logic [31:0] FX_MIN = 32'h80000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  ido_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  ido_pkg::out_item_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [ido_pkg::GAIN_W-1:0] cfg_wdata;

  inverse_depth_observer_step uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // observer copy kept by the testbench
  logic signed [31:0] gain1, gain2, gain3;
  logic pred_on;
  logic signed [31:0] est1, est2, est3;
  logic signed [31:0] last1, last2;
  ido_pkg::out_item_t estimate_q[$];
  int errors;
  bit sink_idle_on;
  bit src_idle_on;
  int sink_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] fx_sat(input logic signed [127:0] v);
    if (v > $signed({96'd0, FX_MAX})) return FX_MAX;
    if (v < -$signed(128'h80000000)) return FX_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, b);
    return fx_sat(128'(a) + 128'(b));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a, b);
    return fx_sat(128'(a) - 128'(b));
  endfunction

  // exact product, truncated toward zero
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a, b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    if (p < 0) p = -((-p) >>> ido_pkg::FRAC_BITS);
    else p = p >>> ido_pkg::FRAC_BITS;
    return fx_sat(p);
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [31:0] n,
                                                input logic [19:0] d);
    logic signed [127:0] q;
    logic signed [127:0] m;
    m = 128'(n);
    if (m < 0) q = -(((-m) <<< ido_pkg::FRAC_BITS) / 128'(d));
    else q = (m <<< ido_pkg::FRAC_BITS) / 128'(d);
    return fx_sat(q);
  endfunction

  task automatic observer_reset();
    gain1 = 32'(ido_pkg::GAIN_INIT);
    gain2 = 32'(ido_pkg::GAIN_INIT);
    gain3 = 32'(ido_pkg::GAIN_INIT);
    pred_on = 1'b1;
    est1 = '0; est2 = '0; est3 = 32'(ido_pkg::INV_DEPTH_INIT);
    last1 = '0; last2 = '0;
  endtask

  // works out the estimate after one item; returns 0 when no result is due
  function automatic bit observer_update(input ido_pkg::in_item_t it,
                                         output ido_pkg::out_item_t r);
    logic signed [31:0] y1, y2, b1, b2, b3, a1, a2, a3, one, dt;
    logic signed [31:0] d1, d2, d3, w1, w2, w3, h1, h2, y12, p1, p2, e1, e2, v1, v2, t;
    logic signed [31:0] x12, o1, o2;
    y1 = it.meas_x; y2 = it.meas_y;
    b1 = it.rel_vel_x; b2 = it.rel_vel_y; b3 = it.rel_vel_z;
    a1 = it.ang_vel_x; a2 = it.ang_vel_y; a3 = it.ang_vel_z;
    one = 32'(ido_pkg::ONE_FX);
    dt = 32'(it.delta_t);
    d1 = '0; d2 = '0; d3 = '0;
    if (!it.action) begin
      if (it.delta_t == 0) return 0;
      w1 = fx_sub(0, a1); w2 = fx_sub(0, a2); w3 = fx_sub(0, a3);
      h1 = fx_sub(b1, fx_mul(y1, b3));
      h2 = fx_sub(b2, fx_mul(y2, b3));
      y12 = fx_mul(y1, y2);
      p1 = fx_sub(fx_add(fx_sub(0, fx_mul(y12, w1)),
                         fx_mul(fx_add(one, fx_mul(y1, y1)), w2)), fx_mul(y2, w3));
      p2 = fx_add(fx_add(fx_sub(0, fx_mul(fx_add(one, fx_mul(y2, y2)), w1)),
                         fx_mul(y12, w2)), fx_mul(y1, w3));
      e1 = fx_sub(y1, est1);
      e2 = fx_sub(y2, est2);
      v1 = fx_div(fx_sub(y1, last1), it.delta_t);
      v2 = fx_div(fx_sub(y2, last2), it.delta_t);
      d1 = fx_add(fx_add(fx_mul(h1, est3), p1), fx_mul(gain1, e1));
      d2 = fx_add(fx_add(fx_mul(h2, est3), p2), fx_mul(gain2, e2));
      t = fx_sub(0, fx_mul(b3, fx_mul(est3, est3)));
      t = fx_add(t, fx_mul(fx_sub(fx_mul(y1, w2), fx_mul(y2, w1)), est3));
      t = fx_sub(t, fx_mul(fx_mul(gain3, fx_add(fx_mul(h1, h1), fx_mul(h2, h2))), est3));
      t = fx_add(t, fx_mul(fx_mul(gain3, h1), fx_sub(v1, p1)));
      t = fx_add(t, fx_mul(fx_mul(gain3, h2), fx_sub(v2, p2)));
      t = fx_add(t, fx_mul(h1, e1));
      d3 = fx_add(t, fx_mul(h2, e2));
    end else if (pred_on) begin
      x12 = fx_mul(est1, est2);
      o1 = fx_add(fx_sub(fx_sub(fx_mul(a3, est2), a2), fx_mul(a2, fx_mul(est1, est1))),
                  fx_mul(a1, x12));
      o2 = fx_add(fx_sub(fx_sub(a1, fx_mul(a3, est1)), fx_mul(a2, x12)),
                  fx_mul(a1, fx_mul(est2, est2)));
      d1 = fx_add(o1, fx_mul(fx_sub(b1, fx_mul(est1, b3)), est3));
      d2 = fx_add(o2, fx_mul(fx_sub(b2, fx_mul(est2, b3)), est3));
      d3 = fx_sub(fx_sub(0, fx_mul(b3, fx_mul(est3, est3))),
                  fx_mul(fx_sub(fx_mul(a2, est1), fx_mul(a1, est2)), est3));
    end
    est1 = fx_add(est1, fx_mul(d1, dt));
    est2 = fx_add(est2, fx_mul(d2, dt));
    est3 = fx_add(est3, fx_mul(d3, dt));
    last1 = y1; last2 = y2;
    r.est_x = est1; r.est_y = est2; r.est_inv_depth = est3;
    r.was_predicted = it.action;
    return 1;
  endfunction

  // one input transfer, with an optional random gap first; valid stays high
  // after the transfer so that back-to-back items need no extra edge
  task automatic send_item(input ido_pkg::in_item_t it);
    ido_pkg::out_item_t r;
    int gap;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (observer_update(it, r)) estimate_q = {estimate_q, r};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (estimate_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ido_pkg::GAIN_W-1:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ido_pkg::CFG_GAIN_ONE:   gain1 = 32'(v);
      ido_pkg::CFG_GAIN_TWO:   gain2 = 32'(v);
      ido_pkg::CFG_GAIN_THREE: gain3 = 32'(v);
      ido_pkg::CFG_PRED_EN:    pred_on = v[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rnd_fx();
    case ($urandom_range(0, 9))
      0: return FX_MAX;
      1: return FX_MIN;
      2: return $urandom;
      3, 4: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      default: return 32'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
    endcase
  endfunction

  function automatic ido_pkg::in_item_t rnd_item(input bit tame);
    ido_pkg::in_item_t it;
    it.action = $urandom_range(0, 2) == 0;
    if (tame) begin
      it.meas_x = 32'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
      it.meas_y = 32'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
      it.rel_vel_x = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      it.rel_vel_y = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      it.rel_vel_z = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      it.ang_vel_x = 32'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
      it.ang_vel_y = 32'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
      it.ang_vel_z = 32'($signed($urandom_range(0, 32'h1ffff)) - 32'sh10000);
      it.delta_t = $urandom_range(0, 15) == 0 ? 20'd0 : 20'($urandom_range(1, 3000));
    end else begin
      it.meas_x = rnd_fx(); it.meas_y = rnd_fx();
      it.rel_vel_x = rnd_fx(); it.rel_vel_y = rnd_fx(); it.rel_vel_z = rnd_fx();
      it.ang_vel_x = rnd_fx(); it.ang_vel_y = rnd_fx(); it.ang_vel_z = rnd_fx();
      case ($urandom_range(0, 3))
        0: it.delta_t = 20'hfffff;
        1: it.delta_t = 20'd0;
        default: it.delta_t = 20'($urandom);
      endcase
    end
    return it;
  endfunction

  task automatic test_directed();
    ido_pkg::in_item_t it;
    it = '0;
    it.delta_t = 20'd0; send_item(it);              // zero step measurement
    it.action = 1'b1; send_item(it);                // zero step predict
    it = '0; it.meas_x = 32'h8000; it.meas_y = -32'sh4000;
    it.rel_vel_x = 32'h10000; it.rel_vel_z = 32'h20000; it.ang_vel_y = 32'h1000;
    it.delta_t = 20'd655; send_item(it);
    it.action = 1'b1; send_item(it);
    it = '1; it.action = 1'b0; send_item(it);       // every bit set
    it.action = 1'b1; send_item(it);
    it.meas_x = FX_MAX; it.meas_y = FX_MIN; it.rel_vel_x = FX_MIN;
    it.rel_vel_y = FX_MAX; it.rel_vel_z = FX_MIN; it.ang_vel_x = FX_MAX;
    it.ang_vel_y = FX_MIN; it.ang_vel_z = FX_MAX; it.delta_t = 20'd1;
    it.action = 1'b0; send_item(it);
    it.action = 1'b1; send_item(it);
    it.delta_t = 20'hfffff; it.action = 1'b0; send_item(it);
    wait_drained();
    write_reg(ido_pkg::CFG_PRED_EN, '0);            // held estimate
    it.action = 1'b1; send_item(it);
    it.delta_t = 20'd0; send_item(it);
    wait_drained();
  endtask

  task automatic test_gain_settings();
    logic [ido_pkg::GAIN_W-1:0] g[4];
    g[0] = '0; g[1] = '1; g[2] = 31'h10000; g[3] = ido_pkg::GAIN_INIT;
    for (int s = 0; s < 4; s++) begin
      write_reg(ido_pkg::CFG_GAIN_ONE, g[s]);
      write_reg(ido_pkg::CFG_GAIN_TWO, g[(s + 1) % 4]);
      write_reg(ido_pkg::CFG_GAIN_THREE, g[(s + 2) % 4]);
      write_reg(ido_pkg::CFG_PRED_EN, ido_pkg::GAIN_W'(s % 2));
      for (int i = 0; i < 30; i++) send_item(rnd_item($urandom_range(0, 3) != 0));
      wait_drained();
    end
    write_reg(ido_pkg::CFG_PRED_EN, ido_pkg::GAIN_W'(1));
  endtask

  // receiver holds off while items keep coming
  task automatic test_backpressure();
    sink_hold = 3000;
    for (int i = 0; i < 6; i++) send_item(rnd_item(1));
    wait_drained();
  endtask

  task automatic test_random(input int n, input bit idle);
    src_idle_on = idle; sink_idle_on = idle;
    for (int i = 0; i < n; i++) send_item(rnd_item($urandom_range(0, 4) != 0));
  endtask

  // receiver stall: random bursts, plus a long hold when requested
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_stall <= 1'b1;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
        out_stall <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    ido_pkg::out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (estimate_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = estimate_q.pop_front();
        if (out_data.est_x !== exp_r.est_x) begin
          $display("%0t: est_x expected %h actual %h", $time, exp_r.est_x, out_data.est_x);
          errors++;
        end
        if (out_data.est_y !== exp_r.est_y) begin
          $display("%0t: est_y expected %h actual %h", $time, exp_r.est_y, out_data.est_y);
          errors++;
        end
        if (out_data.est_inv_depth !== exp_r.est_inv_depth) begin
          $display("%0t: est_inv_depth expected %h actual %h", $time,
                   exp_r.est_inv_depth, out_data.est_inv_depth);
          errors++;
        end
        if (out_data.was_predicted !== exp_r.was_predicted) begin
          $display("%0t: was_predicted expected %b actual %b", $time,
                   exp_r.was_predicted, out_data.was_predicted);
          errors++;
        end
      end
    end
  end

  initial begin
    #50000000;
    $display("** inverse_depth_observer_step: FAILED **");
    $finish;
  end

  initial begin
    errors = 0; sink_hold = 0; src_idle_on = 1'b1; sink_idle_on = 1'b1;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    observer_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_gain_settings();
    test_backpressure();
    test_random(1400, 1'b1);
    wait_drained();
    test_random(350, 1'b0);
    wait_drained();
    if (errors == 0 && estimate_q.size() == 0) begin
      $display("** inverse_depth_observer_step: PASSED **");
    end else begin
      $display("** inverse_depth_observer_step: FAILED **");
    end
    $finish;
  end
endmodule
